>>> rtl/bdfd_pkg.sv
// ============================================================================
// Block delta frame decoder package
// Shared types, codes and default constants of the block delta frame decoder.
// ============================================================================
package bdfd_pkg;

    localparam int DEF_FRAME_PIXELS = 65536;
    localparam int DEF_MAX_BLOCK    = 16;

    localparam logic [4:0]  RST_BLOCK_SIZE   = 5'd8;
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd256;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd256;

    localparam int IDX_W = 16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_DELTA = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BLOCK_SIZE   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_CNT_LO,
        PH_CNT_HI,
        PH_IDX_LO,
        PH_IDX_HI,
        PH_PIX
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GW_GO,
        ST_GW_WAIT,
        ST_IDX_GO,
        ST_IDX_WAIT,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [4:0]  block_size;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       delta_done;
        logic       bad_block;
    } res_t;

endpackage

>>> rtl/bdfd_div.sv
// ============================================================================
// Block delta frame decoder divider
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module bdfd_div #(
    parameter int W = bdfd_pkg::IDX_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] numerator,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  den_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            quo_next  = numerator;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/bdfd_mem.sv
// ============================================================================
// Block delta frame decoder frame store
// Single-port pixel memory with a registered read.
// ============================================================================
module bdfd_mem #(
    parameter int DEPTH = bdfd_pkg::DEF_FRAME_PIXELS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] store [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bdfd_ctrl.sv
// ============================================================================
// Block delta frame decoder control
// Delta stream parser, block header address calculation and item sequencing.
// ============================================================================
module bdfd_ctrl #(
    parameter int AW        = 16,
    parameter int MAX_BLOCK = bdfd_pkg::DEF_MAX_BLOCK
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bdfd_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [7:0]         data_byte,
    input  logic [15:0]        pixel_address,
    input  logic               out_free,
    output logic               res_valid,
    output bdfd_pkg::res_t     res,
    output logic               mem_we,
    output logic               mem_re,
    output logic [AW-1:0]      mem_addr,
    output logic [7:0]         mem_wdata,
    input  logic [7:0]         mem_rdata
);

    localparam int BSW = $clog2(MAX_BLOCK + 1);
    localparam int BYW = bdfd_pkg::IDX_W + BSW;

    bdfd_pkg::state_t state_reg;
    bdfd_pkg::state_t state_next;
    bdfd_pkg::phase_t phase_reg;
    bdfd_pkg::phase_t phase_next;
    bdfd_pkg::res_t   res_reg;
    bdfd_pkg::res_t   res_next;

    logic [15:0]    blocks_reg;
    logic [15:0]    blocks_next;
    logic [15:0]    blocks_dec;
    logic [7:0]     held_reg;
    logic [7:0]     held_next;
    logic [BSW-1:0] row_reg;
    logic [BSW-1:0] row_next;
    logic [BSW-1:0] col_reg;
    logic [BSW-1:0] col_next;
    logic [AW-1:0]  base_reg;
    logic [AW-1:0]  base_next;
    logic           grid_reg;
    logic           grid_next;
    logic [15:0]    idx_reg;
    logic [15:0]    idx_next;
    logic [BYW-1:0] bybs_reg;
    logic [BYW-1:0] bybs_next;
    logic [BYW-1:0] bxbs_reg;
    logic [BYW-1:0] bxbs_next;

    logic [BSW-1:0] bs;
    logic           accept;
    logic           col_end;
    logic           row_end;
    logic           div_start;
    logic [15:0]    div_num;
    logic [15:0]    div_den;
    logic           div_done;
    logic [15:0]    div_q;
    logic [15:0]    div_r;

    bdfd_div #(
        .W(bdfd_pkg::IDX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        if (cfg.block_size == 5'd0)
        begin
            bs = BSW'(1);
        end
        else if (int'(cfg.block_size) > MAX_BLOCK)
        begin
            bs = BSW'(MAX_BLOCK);
        end
        else
        begin
            bs = BSW'(cfg.block_size);
        end
    end

    assign in_stall   = (state_reg != bdfd_pkg::ST_IDLE);
    assign accept     = in_valid && (state_reg == bdfd_pkg::ST_IDLE);
    assign col_end    = ((BSW + 1)'(col_reg) + (BSW + 1)'(1)) >= (BSW + 1)'(bs);
    assign row_end    = ((BSW + 1)'(row_reg) + (BSW + 1)'(1)) >= (BSW + 1)'(bs);
    assign blocks_dec = blocks_reg - 16'd1;
    assign mem_wdata  = data_byte;
    assign div_start  = (state_reg == bdfd_pkg::ST_GW_GO)
                     || (state_reg == bdfd_pkg::ST_IDX_GO);
    assign div_num    = (state_reg == bdfd_pkg::ST_GW_GO) ? 16'(cfg.frame_width) : idx_reg;
    assign div_den    = (state_reg == bdfd_pkg::ST_GW_GO) ? 16'(bs) : div_q;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        res_next    = res_reg;
        blocks_next = blocks_reg;
        held_next   = held_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        grid_next   = grid_reg;
        idx_next    = idx_reg;
        bybs_next   = bybs_reg;
        bxbs_next   = bxbs_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = AW'(pixel_address);
        res_valid   = 1'b0;
        case (state_reg)
            bdfd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = bdfd_pkg::ST_DONE;
                    case (bdfd_pkg::mode_t'(mode))
                        bdfd_pkg::MODE_LOAD:
                        begin
                            mem_we      = 1'b1;
                            phase_next  = bdfd_pkg::PH_CNT_LO;
                            blocks_next = '0;
                            held_next   = '0;
                            row_next    = '0;
                            col_next    = '0;
                            base_next   = '0;
                            grid_next   = 1'b0;
                        end
                        bdfd_pkg::MODE_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = bdfd_pkg::ST_READ;
                        end
                        bdfd_pkg::MODE_DELTA:
                        begin
                            case (phase_reg)
                                bdfd_pkg::PH_CNT_LO:
                                begin
                                    held_next  = data_byte;
                                    phase_next = bdfd_pkg::PH_CNT_HI;
                                end
                                bdfd_pkg::PH_CNT_HI:
                                begin
                                    blocks_next = {data_byte, held_reg};
                                    if ({data_byte, held_reg} == 16'd0)
                                    begin
                                        res_next.delta_done = 1'b1;
                                        phase_next          = bdfd_pkg::PH_CNT_LO;
                                    end
                                    else
                                    begin
                                        phase_next = bdfd_pkg::PH_IDX_LO;
                                    end
                                end
                                bdfd_pkg::PH_IDX_LO:
                                begin
                                    held_next  = data_byte;
                                    phase_next = bdfd_pkg::PH_IDX_HI;
                                end
                                bdfd_pkg::PH_IDX_HI:
                                begin
                                    idx_next   = {data_byte, held_reg};
                                    state_next = bdfd_pkg::ST_GW_GO;
                                end
                                bdfd_pkg::PH_PIX:
                                begin
                                    mem_we   = grid_reg;
                                    mem_addr = base_reg + AW'(col_reg);
                                    if (col_end)
                                    begin
                                        col_next  = '0;
                                        base_next = base_reg + AW'(cfg.frame_width);
                                        if (row_end)
                                        begin
                                            row_next    = '0;
                                            blocks_next = blocks_dec;
                                            if (blocks_dec == 16'd0)
                                            begin
                                                res_next.delta_done = 1'b1;
                                                phase_next = bdfd_pkg::PH_CNT_LO;
                                            end
                                            else
                                            begin
                                                phase_next = bdfd_pkg::PH_IDX_LO;
                                            end
                                        end
                                        else
                                        begin
                                            row_next = row_reg + BSW'(1);
                                        end
                                    end
                                    else
                                    begin
                                        col_next = col_reg + BSW'(1);
                                    end
                                end
                                default:
                                begin
                                    phase_next = bdfd_pkg::PH_CNT_LO;
                                end
                            endcase
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            bdfd_pkg::ST_READ:
            begin
                res_next.read_data = mem_rdata;
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = bdfd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bdfd_pkg::ST_DONE;
                end
            end
            bdfd_pkg::ST_GW_GO:
            begin
                state_next = bdfd_pkg::ST_GW_WAIT;
            end
            bdfd_pkg::ST_GW_WAIT:
            begin
                if (div_done)
                begin
                    if (div_q == 16'd0)
                    begin
                        base_next          = '0;
                        grid_next          = 1'b0;
                        row_next           = '0;
                        col_next           = '0;
                        res_next.bad_block = 1'b1;
                        phase_next         = bdfd_pkg::PH_PIX;
                        state_next         = bdfd_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = bdfd_pkg::ST_IDX_GO;
                    end
                end
            end
            bdfd_pkg::ST_IDX_GO:
            begin
                state_next = bdfd_pkg::ST_IDX_WAIT;
            end
            bdfd_pkg::ST_IDX_WAIT:
            begin
                if (div_done)
                begin
                    bybs_next  = BYW'(div_q) * BYW'(bs);
                    bxbs_next  = BYW'(div_r) * BYW'(bs);
                    state_next = bdfd_pkg::ST_MUL;
                end
            end
            bdfd_pkg::ST_MUL:
            begin
                row_next   = '0;
                col_next   = '0;
                phase_next = bdfd_pkg::PH_PIX;
                state_next = bdfd_pkg::ST_DONE;
                if (((BYW + 1)'(bybs_reg) + (BYW + 1)'(bs))
                    <= (BYW + 1)'(cfg.frame_height))
                begin
                    base_next = AW'(AW'(bybs_reg) * AW'(cfg.frame_width)) + AW'(bxbs_reg);
                    grid_next = 1'b1;
                end
                else
                begin
                    base_next          = '0;
                    grid_next          = 1'b0;
                    res_next.bad_block = 1'b1;
                end
            end
            bdfd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = bdfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bdfd_pkg::ST_IDLE;
            phase_reg  <= bdfd_pkg::PH_CNT_LO;
            blocks_reg <= '0;
            held_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            base_reg   <= '0;
            grid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            blocks_reg <= blocks_next;
            held_reg   <= held_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            base_reg   <= base_next;
            grid_reg   <= grid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        idx_reg  <= idx_next;
        bybs_reg <= bybs_next;
        bxbs_reg <= bxbs_next;
    end

    assign res = (state_reg == bdfd_pkg::ST_READ) ? res_next : res_reg;

endmodule

>>> rtl/block_delta_frame_decoder.sv
// ============================================================================
// Block delta frame decoder
// Grayscale frame store updated by a stream of block replacement deltas.
// ============================================================================
// Each input item carries a mode, a byte and a pixel address. A load item
// writes a keyframe pixel and restarts the delta parser, a read item returns
// the stored pixel, and a delta item feeds one byte of the delta stream.
// Every accepted item gives exactly one result item on the output channel,
// holding the read pixel and the delta completion and bad block flags.
// Most items pass from idle through the done state into the output register,
// and the input stalls until the result is written there, so a new item is
// not accepted before the last one is through. The byte that completes a block
// index first passes twice through the bit-serial divider (grid width, then
// block column and row) and two multiply stages that form the block address,
// or only the first divider pass when the grid has no block columns.
// The output register lets a new item be accepted while a result waits.
// When the receiver stalls, a further finished result waits inside the
// block and the input stalls until the output register frees.
// Reset restores the register defaults and the parser state; the frame
// store holds no defined contents until its pixels are written.
// Configuration writes are always ready and must be made while idle.
// ============================================================================
module block_delta_frame_decoder #(
    parameter int FRAME_PIXELS = bdfd_pkg::DEF_FRAME_PIXELS,
    parameter int MAX_BLOCK    = bdfd_pkg::DEF_MAX_BLOCK
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic [15:0] pixel_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        delta_done,
    output logic        bad_block
);

    localparam int AW = $clog2(FRAME_PIXELS);

    bdfd_pkg::cfg_t cfg_reg;
    bdfd_pkg::cfg_t cfg_next;
    bdfd_pkg::res_t res;
    bdfd_pkg::res_t out_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;
    logic          res_valid;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (bdfd_pkg::cfg_index_t'(cfg_index))
                bdfd_pkg::CFG_BLOCK_SIZE:   cfg_next.block_size   = cfg_data[4:0];
                bdfd_pkg::CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                bdfd_pkg::CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                default:                    cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size   <= bdfd_pkg::RST_BLOCK_SIZE;
            cfg_reg.frame_width  <= bdfd_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= bdfd_pkg::RST_FRAME_HEIGHT;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    bdfd_mem #(
        .DEPTH(FRAME_PIXELS),
        .AW   (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bdfd_ctrl #(
        .AW       (AW),
        .MAX_BLOCK(MAX_BLOCK)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .data_byte     (data_byte),
        .pixel_address (pixel_address),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .mem_we        (mem_we),
        .mem_re        (mem_re),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign read_data  = out_reg.read_data;
    assign delta_done = out_reg.delta_done;
    assign bad_block  = out_reg.bad_block;

endmodule
